// ----- design/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types for the controller and the datapath: state codes, the command
// bundle and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int ADDR_W = 19;

    typedef enum logic [14:0] {
        S_CLEAR   = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_FIT     = 15'b000000000000100,
        S_LVL     = 15'b000000000001000,
        S_SCAN_RD = 15'b000000000010000,
        S_SCAN_CK = 15'b000000000100000,
        S_SPLIT   = 15'b000000001000000,
        S_GRANT   = 15'b000000010000000,
        S_FDIV    = 15'b000000100000000,
        S_FCHK    = 15'b000001000000000,
        S_FGL     = 15'b000010000000000,
        S_MRG_RD  = 15'b000100000000000,
        S_MRG_CK  = 15'b001000000000000,
        S_DONE    = 15'b010000000000000,
        S_SPARE   = 15'b100000000000000
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic fit;
        logic lvl;
        logic scan_rd;
        logic scan_next;
        logic take;
        logic split;
        logic grant;
        logic fdiv;
        logic gl_rd;
        logic gl_clr;
        logic mrg_rd;
        logic merge;
        logic settle;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic alloc_none;
        logic fm_bit;
        logic at_fit;
        logic free_bad;
        logic gl_valid;
        logic at_top;
    } t_sts;

endpackage

`default_nettype wire

// ----- design/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences the clearing pass, the allocation search and split, and the free
// merge by issuing one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_mode,
    input  wire bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? bba_pkg::S_FDIV : bba_pkg::S_FIT;
                end
            end
            bba_pkg::S_FIT: begin
                o_cmd.fit = 1'b1;
                n_state   = bba_pkg::S_LVL;
            end
            bba_pkg::S_LVL: begin
                if (i_sts.alloc_none) begin
                    n_state = bba_pkg::S_DONE;
                end else begin
                    o_cmd.lvl = 1'b1;
                    n_state   = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = bba_pkg::S_SCAN_CK;
            end
            bba_pkg::S_SCAN_CK: begin
                if (i_sts.fm_bit) begin
                    o_cmd.take = 1'b1;
                    n_state    = bba_pkg::S_SPLIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SPLIT: begin
                if (i_sts.at_fit) begin
                    n_state = bba_pkg::S_GRANT;
                end else begin
                    o_cmd.split = 1'b1;
                end
            end
            bba_pkg::S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state     = bba_pkg::S_DONE;
            end
            bba_pkg::S_FDIV: begin
                o_cmd.fdiv = 1'b1;
                n_state    = bba_pkg::S_FCHK;
            end
            bba_pkg::S_FCHK: begin
                if (i_sts.free_bad) begin
                    n_state = bba_pkg::S_DONE;
                end else begin
                    o_cmd.gl_rd = 1'b1;
                    n_state     = bba_pkg::S_FGL;
                end
            end
            bba_pkg::S_FGL: begin
                if (!i_sts.gl_valid) begin
                    n_state = bba_pkg::S_DONE;
                end else begin
                    o_cmd.gl_clr = 1'b1;
                    n_state      = bba_pkg::S_MRG_RD;
                end
            end
            bba_pkg::S_MRG_RD: begin
                if (i_sts.at_top) begin
                    o_cmd.settle = 1'b1;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    o_cmd.mrg_rd = 1'b1;
                    n_state      = bba_pkg::S_MRG_CK;
                end
            end
            bba_pkg::S_MRG_CK: begin
                if (i_sts.fm_bit) begin
                    o_cmd.merge = 1'b1;
                    n_state     = bba_pkg::S_MRG_RD;
                end else begin
                    o_cmd.settle = 1'b1;
                    n_state      = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_DONE: begin
                n_state = bba_pkg::S_IDLE;
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != bba_pkg::S_IDLE);
    assign o_strobe = (r_state == bba_pkg::S_DONE);

endmodule

`default_nettype wire

// ----- design/bba_dpath.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Holds the free-map tree memory, the granted-level memory, the per-level
// free counts and the working registers, and acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath #(
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int NUM_MIN_BLOCKS  = 4096,
    parameter int HEADER_BYTES    = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bba_pkg::t_cmd              i_cmd,
    input  wire logic                       i_mode,
    input  wire logic [bba_pkg::ADDR_W-1:0] i_request_length,
    input  wire logic [bba_pkg::ADDR_W-1:0] i_block_address,
    output bba_pkg::t_sts                   o_sts,
    output logic                            o_status,
    output logic [bba_pkg::ADDR_W-1:0]      o_granted_address
);

    localparam int AW    = bba_pkg::ADDR_W;
    localparam int TOP   = $clog2(NUM_MIN_BLOCKS);
    localparam int LW    = $clog2(TOP + 1);
    localparam int BW    = $clog2(NUM_MIN_BLOCKS);
    localparam int NODES = 2 * NUM_MIN_BLOCKS - 1;
    localparam int NW    = $clog2(2 * NUM_MIN_BLOCKS);
    localparam int CW    = $clog2(NUM_MIN_BLOCKS + 1);
    localparam int SHIFT = AW + $clog2(MIN_BLOCK_BYTES);
    localparam logic [20:0] RECIP =
        21'(((64'd1 << SHIFT) + 64'(MIN_BLOCK_BYTES) - 64'd1) / 64'(MIN_BLOCK_BYTES));

    function automatic logic [NW-1:0] node_of(input logic [LW-1:0] lv,
                                              input logic [BW-1:0] b);
        logic [NW:0] base;
        base = ((NW+1)'(1) << (LW'(TOP) - lv)) - (NW+1)'(1);
        return NW'(base + (NW+1)'(b));
    endfunction

    logic            fm_mem [0:NODES-1];
    logic            fm_q;
    logic            fm_we, fm_re, fm_wd;
    logic [NW-1:0]   fm_wa, fm_ra;

    logic [LW:0]     gl_mem [0:NUM_MIN_BLOCKS-1];
    logic [LW:0]     gl_q;
    logic            gl_we;
    logic [BW-1:0]   gl_wa;
    logic [LW:0]     gl_wd;

    logic [NW-1:0]   r_clr;
    logic [CW-1:0]   r_cnt [0:TOP];
    logic [CW-1:0]   n_cnt [0:TOP];
    logic            cnt_inc, cnt_dec;
    logic [LW-1:0]   cnt_lv;

    logic [AW-1:0]   r_len, r_ain, r_off, r_q;
    logic [LW-1:0]   r_fit, r_lv;
    logic            r_over, r_bad;
    logic [BW-1:0]   r_b, r_idx;
    logic            r_status;
    logic [AW-1:0]   r_res;

    logic [AW:0]     need;
    logic [LW-1:0]   fit_lv;
    logic [LW-1:0]   found_lv;
    logic            found;
    logic [AW-1:0]   off;
    logic [39:0]     prod;
    logic [LW-1:0]   lv_dn;
    logic [BW-1:0]   b_up;
    logic [BW-1:0]   gidx;

    assign need  = (AW+1)'(r_len) + (AW+1)'(HEADER_BYTES);
    assign off   = r_ain - AW'(HEADER_BYTES);
    assign prod  = 40'(off) * 40'(RECIP);
    assign lv_dn = r_lv - LW'(1);
    assign b_up  = BW'(r_b << 1) | BW'(1);
    assign gidx  = BW'(r_b << r_lv);

    // Smallest level whose block holds the request plus header.
    always_comb begin
        fit_lv = LW'(TOP);
        for (int l = TOP; l >= 0; l--) begin
            if ((34'(MIN_BLOCK_BYTES) << l) >= 34'(need)) fit_lv = LW'(l);
        end
    end

    // Lowest level at or above the fit that still holds a free block.
    always_comb begin
        found_lv = LW'(TOP);
        found    = 1'b0;
        for (int l = TOP; l >= 0; l--) begin
            if ((LW'(l) >= r_fit) && (r_cnt[l] != '0)) begin
                found_lv = LW'(l);
                found    = 1'b1;
            end
        end
    end

    always_comb begin
        fm_we = 1'b0; fm_wa = '0; fm_wd = 1'b0;
        fm_re = 1'b0; fm_ra = '0;
        cnt_inc = 1'b0; cnt_dec = 1'b0; cnt_lv = r_lv;
        gl_we = 1'b0; gl_wa = '0; gl_wd = '0;
        if (i_cmd.clear) begin
            fm_we = 1'b1;
            fm_wa = r_clr;
            fm_wd = (r_clr == '0);
            gl_we = ((NW+1)'(r_clr) < (NW+1)'(NUM_MIN_BLOCKS));
            gl_wa = BW'(r_clr);
        end
        if (i_cmd.scan_rd) begin
            fm_re = 1'b1;
            fm_ra = node_of(r_lv, r_b);
        end
        if (i_cmd.mrg_rd) begin
            fm_re = 1'b1;
            fm_ra = node_of(r_lv, r_b ^ BW'(1));
        end
        if (i_cmd.take) begin
            fm_we = 1'b1; fm_wa = node_of(r_lv, r_b); fm_wd = 1'b0;
            cnt_dec = 1'b1;
        end
        if (i_cmd.split) begin
            fm_we = 1'b1; fm_wa = node_of(lv_dn, b_up); fm_wd = 1'b1;
            cnt_inc = 1'b1; cnt_lv = lv_dn;
        end
        if (i_cmd.merge) begin
            fm_we = 1'b1; fm_wa = node_of(r_lv, r_b ^ BW'(1)); fm_wd = 1'b0;
            cnt_dec = 1'b1;
        end
        if (i_cmd.settle) begin
            fm_we = 1'b1; fm_wa = node_of(r_lv, r_b); fm_wd = 1'b1;
            cnt_inc = 1'b1;
        end
        if (i_cmd.grant) begin
            gl_we = 1'b1; gl_wa = gidx; gl_wd = {1'b1, r_lv};
        end
        if (i_cmd.gl_clr) begin
            gl_we = 1'b1; gl_wa = r_idx; gl_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) fm_mem[fm_wa] <= fm_wd;
        if (fm_re) fm_q <= fm_mem[fm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (gl_we) gl_mem[gl_wa] <= gl_wd;
        if (i_cmd.gl_rd) gl_q <= gl_mem[BW'(r_q)];
    end

    always_comb begin
        for (int l = 0; l <= TOP; l++) begin
            n_cnt[l] = r_cnt[l];
            if (cnt_lv == LW'(l)) begin
                if (cnt_inc) n_cnt[l] = r_cnt[l] + CW'(1);
                if (cnt_dec) n_cnt[l] = r_cnt[l] - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            for (int l = 0; l <= TOP; l++) begin
                r_cnt[l] <= (l == TOP) ? CW'(1) : CW'(0);
            end
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + NW'(1);
            for (int l = 0; l <= TOP; l++) r_cnt[l] <= n_cnt[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len    <= i_request_length;
            r_ain    <= i_block_address;
            r_status <= !i_mode;
            r_res    <= '0;
        end
        if (i_cmd.fit) begin
            r_fit  <= fit_lv;
            r_over <= 32'(need) > (32'(NUM_MIN_BLOCKS) * 32'(MIN_BLOCK_BYTES));
        end
        if (i_cmd.lvl) begin
            r_lv <= found_lv;
            r_b  <= '0;
        end
        if (i_cmd.scan_next) r_b <= r_b + BW'(1);
        if (i_cmd.split) begin
            r_lv <= lv_dn;
            r_b  <= BW'(r_b << 1);
        end
        if (i_cmd.grant) begin
            r_status <= 1'b0;
            r_res    <= AW'(32'(gidx) * 32'(MIN_BLOCK_BYTES) + 32'(HEADER_BYTES));
        end
        if (i_cmd.fdiv) begin
            r_bad <= (r_ain < AW'(HEADER_BYTES));
            r_off <= off;
            r_q   <= AW'(prod >> SHIFT);
        end
        if (i_cmd.gl_rd) r_idx <= BW'(r_q);
        if (i_cmd.gl_clr) begin
            r_lv <= gl_q[LW-1:0];
            r_b  <= r_idx >> gl_q[LW-1:0];
        end
        if (i_cmd.merge) begin
            r_lv <= r_lv + LW'(1);
            r_b  <= r_b >> 1;
        end
    end

    assign o_sts.clr_last   = (r_clr == NW'(NODES - 1));
    assign o_sts.alloc_none = r_over || !found;
    assign o_sts.fm_bit     = fm_q;
    assign o_sts.at_fit     = (r_lv == r_fit);
    assign o_sts.free_bad   = r_bad
                           || ((32'(r_q) * 32'(MIN_BLOCK_BYTES)) != 32'(r_off))
                           || (32'(r_q) >= 32'(NUM_MIN_BLOCKS));
    assign o_sts.gl_valid   = gl_q[LW];
    assign o_sts.at_top     = (r_lv == LW'(TOP));

    assign o_status          = r_status;
    assign o_granted_address = r_res;

endmodule

`default_nettype wire

// ----- design/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator core
// Binary buddy allocator over an arena of NUM_MIN_BLOCKS minimum blocks.
// ----------------------------------------------------------------------------
// Operation: an allocation scans the free-map nodes at the chosen level L until it finds a free
// one, then splits it down to the fit level F; a free merges upward while the buddy block is
// free, up to the top level. A rejected request ends without a search or a merge.
// Throughput: one item at a time; the next start is taken in the cycle after the strobe.
// Reset: a clearing pass sweeps all 2*NUM_MIN_BLOCKS-1 nodes of the free-map memory with busy
// high. Results cannot be stalled by the receiver.
`default_nettype none

module buddy_block_allocator_core #(
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int NUM_MIN_BLOCKS  = 4096,
    parameter int HEADER_BYTES    = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_mode,
    input  wire logic [bba_pkg::ADDR_W-1:0] i_request_length,
    input  wire logic [bba_pkg::ADDR_W-1:0] i_block_address,
    output logic                            o_strobe,
    output logic                            o_status,
    output logic [bba_pkg::ADDR_W-1:0]      o_granted_address
);

    // The controller owns sequencing; every state change in the memories
    // and counters is driven by one command bundle per cycle.
    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    bba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // The datapath holds the free-map tree (root first, children of node n
    // at 2n+1 and 2n+2), the level granted at each minimum-block index with
    // its in-use flag, and a free count per level so the search jumps
    // straight to the first level that holds a free block.
    bba_dpath #(
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .NUM_MIN_BLOCKS  (NUM_MIN_BLOCKS),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_mode),
        .i_request_length  (i_request_length),
        .i_block_address   (i_block_address),
        .o_sts             (sts),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

    // The result strobe lasts exactly one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // An accepted transfer makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transfer");

    // A failed allocation always reports a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (o_granted_address == '0))
        else $error("failed result carries a nonzero address");

    // Reset starts the clearing pass, during which no transfer is taken.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset");

endmodule

`default_nettype wire
